[rtl/ms_pkg.sv]
// ----------------------------------------------------------------------------
// Merge sorter package
// Shared types and sizing constants for the merge sorter block.
// ----------------------------------------------------------------------------
package ms_pkg;

	// Capacity of one set, in values (2 .. 4096)
	localparam int MAX_ITEMS = 64;
	// Fill count holds 0 .. MAX_ITEMS
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_W = $clog2(MAX_ITEMS);
	// One extra bit for run bounds before clamping
	localparam int EXT_W = CNT_W + 1;

	// Set descriptor queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic end_of_set;
		logic truncated;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic truncated;
	} desc_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] addr;
		logic signed [DATA_W-1:0] data;
	} wr_req_t;

endpackage

[rtl/ms_front.sv]
// ----------------------------------------------------------------------------
// Merge sorter front end
// Accepts input items, writes values into the store and closes each set.
// ----------------------------------------------------------------------------
module ms_front import ms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output wr_req_t wr,
	output logic push,
	output desc_t desc,
	input logic q_full,
	input logic set_done
);

	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic wait_q;

	logic acc;
	logic room;
	logic [CNT_W-1:0] cnt_nx;
	logic ovf_nx;

	assign item_stall = wait_q || q_full;
	assign acc = item_valid && !item_stall;
	assign room = cnt_q < CNT_W'(MAX_ITEMS);

	assign cnt_nx = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign ovf_nx = ovf_q || !room;

	assign wr.we = acc && room;
	assign wr.addr = cnt_q[ADDR_W-1:0];
	assign wr.data = item.value;

	assign push = acc && item.last;
	assign desc.count = cnt_nx;
	assign desc.truncated = ovf_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			if (acc) begin
				if (item.last) begin
					// seal the set: hold input until the back releases the store
					cnt_q <= '0;
					ovf_q <= 1'b0;
					wait_q <= 1'b1;
				end else begin
					cnt_q <= cnt_nx;
					ovf_q <= ovf_nx;
				end
			end else if (set_done) begin
				wait_q <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("fill count above capacity");

endmodule

[rtl/ms_fifo.sv]
// ----------------------------------------------------------------------------
// Merge sorter descriptor queue
// Short queue of sealed set descriptors between front and back.
// ----------------------------------------------------------------------------
module ms_fifo import ms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input desc_t push_desc,
	input logic pop,
	output logic valid,
	output logic full,
	output desc_t head
);

	desc_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign valid = count_q != '0;
	assign full = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			// pointers wrap naturally: depth is a power of two
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("descriptor queue overrun");

endmodule

[rtl/ms_back.sv]
// ----------------------------------------------------------------------------
// Merge sorter back end
// Owns the value store and scratch memories, runs the merge passes, emits.
// ----------------------------------------------------------------------------
module ms_back import ms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic desc_valid,
	input desc_t desc,
	output logic desc_pop,
	input wr_req_t wr,
	output logic set_done,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_MERGE = 3'd2;
	localparam logic [2:0] ST_EMIT_RD = 3'd3;
	localparam logic [2:0] ST_EMIT_LD = 3'd4;

	// bank 0 is the value store, bank 1 the merge scratch
	logic signed [DATA_W-1:0] bank0 [MAX_ITEMS];
	logic signed [DATA_W-1:0] bank1 [MAX_ITEMS];
	logic signed [DATA_W-1:0] rd0_a_q, rd0_b_q, rd1_a_q, rd1_b_q;

	logic [2:0] state_q;
	logic [CNT_W-1:0] n_q, width_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic trunc_q;
	logic src_q;
	logic out_valid_q;
	result_t out_q;

	logic [EXT_W-1:0] n_ext, mid_sum, hi_sum, w2;
	logic [CNT_W-1:0] mid_run, hi_run, i_nx, j_nx, k_nx;
	logic signed [DATA_W-1:0] head_a, head_b, mdata;
	logic a_live, b_live, take_b;
	logic run_end, pass_end, sort_end;
	logic [ADDR_W-1:0] addr_a, addr_b;
	logic mwe, we0, we1;
	logic [ADDR_W-1:0] waddr0;
	logic signed [DATA_W-1:0] wdata0;
	logic slot_free, emit_load, emit_final;

	// run bounds, clamped to the set size
	assign n_ext = {1'b0, n_q};
	assign mid_sum = {1'b0, lo_q} + {1'b0, width_q};
	assign hi_sum = {1'b0, lo_q} + {width_q, 1'b0};
	assign mid_run = (mid_sum > n_ext) ? n_q : mid_sum[CNT_W-1:0];
	assign hi_run = (hi_sum > n_ext) ? n_q : hi_sum[CNT_W-1:0];
	assign w2 = {width_q, 1'b0};

	// merge step: heads sit in the read registers of the source bank
	assign head_a = src_q ? rd1_a_q : rd0_a_q;
	assign head_b = src_q ? rd1_b_q : rd0_b_q;
	assign a_live = i_q < mid_q;
	assign b_live = j_q < hi_q;
	assign take_b = b_live && (!a_live || (head_b < head_a));
	assign i_nx = take_b ? i_q : i_q + CNT_W'(1);
	assign j_nx = take_b ? j_q + CNT_W'(1) : j_q;
	assign k_nx = k_q + CNT_W'(1);
	assign run_end = k_nx == hi_q;
	assign pass_end = hi_q == n_q;
	assign sort_end = w2 >= n_ext;
	assign mdata = take_b ? head_b : head_a;

	always_comb begin
		unique case (state_q)
			ST_PRIME: begin
				addr_a = lo_q[ADDR_W-1:0];
				addr_b = mid_run[ADDR_W-1:0];
			end
			ST_MERGE: begin
				addr_a = i_nx[ADDR_W-1:0];
				addr_b = j_nx[ADDR_W-1:0];
			end
			default: begin
				addr_a = k_q[ADDR_W-1:0];
				addr_b = k_q[ADDR_W-1:0];
			end
		endcase
	end

	// write ports: merge output goes to the bank that is not the source
	assign mwe = state_q == ST_MERGE;
	assign we0 = (mwe && src_q) || wr.we;
	assign waddr0 = mwe ? k_q[ADDR_W-1:0] : wr.addr;
	assign wdata0 = mwe ? mdata : wr.data;
	assign we1 = mwe && !src_q;

	always_ff @(posedge clk) begin
		if (we0) begin
			bank0[waddr0] <= wdata0;
		end
		rd0_a_q <= bank0[addr_a];
		rd0_b_q <= bank0[addr_b];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			bank1[k_q[ADDR_W-1:0]] <= mdata;
		end
		rd1_a_q <= bank1[addr_a];
		rd1_b_q <= bank1[addr_b];
	end

	assign slot_free = !out_valid_q || !result_stall;
	assign emit_load = (state_q == ST_EMIT_LD) && slot_free;
	assign emit_final = k_nx == n_q;
	assign desc_pop = (state_q == ST_IDLE) && desc_valid;
	assign set_done = emit_load && emit_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			trunc_q <= 1'b0;
			width_q <= '0;
			lo_q <= '0;
			mid_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			src_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (desc_valid) begin
						n_q <= desc.count;
						trunc_q <= desc.truncated;
						width_q <= CNT_W'(1);
						lo_q <= '0;
						k_q <= '0;
						src_q <= 1'b0;
						state_q <= (desc.count > CNT_W'(1)) ? ST_PRIME : ST_EMIT_RD;
					end
				end
				ST_PRIME: begin
					mid_q <= mid_run;
					hi_q <= hi_run;
					i_q <= lo_q;
					j_q <= mid_run;
					k_q <= lo_q;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					i_q <= i_nx;
					j_q <= j_nx;
					k_q <= k_nx;
					if (run_end) begin
						if (pass_end) begin
							// flip banks and double the run width
							src_q <= !src_q;
							lo_q <= '0;
							if (sort_end) begin
								k_q <= '0;
								state_q <= ST_EMIT_RD;
							end else begin
								width_q <= w2[CNT_W-1:0];
								state_q <= ST_PRIME;
							end
						end else begin
							lo_q <= hi_q;
							state_q <= ST_PRIME;
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (slot_free) begin
						k_q <= k_nx;
						state_q <= emit_final ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q.sorted_value <= head_a;
			out_q.end_of_set <= emit_final;
			out_q.truncated <= trunc_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	a_merge_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (k_q < hi_q))
		else $error("merge write beyond run");

	a_store_owned: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == ST_IDLE))
		else $error("store written while back end busy");

	a_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		set_done |=> (out_valid_q && out_q.end_of_set))
		else $error("set released without final value in output register");

endmodule

[rtl/merge_sorter.sv]
// ----------------------------------------------------------------------------
// Merge sorter
// Buffers a set of signed 32-bit values, sorts them ascending, emits them.
// ----------------------------------------------------------------------------
// Values arrive one per transfer; the transfer with last set closes the set.
// The front end writes each accepted value into the store and drops values
// beyond MAX_ITEMS, flagging truncated on every result of that set. A sealed
// set goes through a short descriptor queue to the back end, which runs a
// bottom-up merge sort, ping-ponging between the store and a scratch memory:
// ceil(log2 n) passes, each with one priming step per run pair and the
// two-read-port memory feeding one compare per cycle. Results then leave
// through an output register, each value taking a memory read and then a
// load, the load waiting while a held result is stalled. The front end
// holds off the next set until the back end has read out the last value;
// ties come out in arrival order. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module merge_sorter import ms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	wr_req_t wr;
	desc_t push_desc;
	desc_t head_desc;
	logic push;
	logic pop;
	logic q_valid;
	logic q_full;
	logic set_done;

	// accept and store values, seal sets
	ms_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.wr(wr),
		.push(push),
		.desc(push_desc),
		.q_full(q_full),
		.set_done(set_done)
	);

	// hold sealed set descriptors until the back end picks them up
	ms_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_desc(push_desc),
		.pop(pop),
		.valid(q_valid),
		.full(q_full),
		.head(head_desc)
	);

	// sort and emit; release the store once the last value is read out
	ms_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.desc_valid(q_valid),
		.desc(head_desc),
		.desc_pop(pop),
		.wr(wr),
		.set_done(set_done),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sorter testbench
// Feeds sets of signed values through the sorter, predicts the ascending
// output of each set (including the truncation flag when a set overflows
// the store) and checks every result transfer against the prediction, under
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
	import ms_pkg::*;

	// Longest stretch without any transfer before the run is declared hung.
	// Covers a full-set sort, the forced output hold-off and the longest random
	// gaps, several times over.
	localparam int WATCHDOG_LIMIT = 8000;
	// Quiet cycles after the last expected result, to catch stray results
	localparam int TAIL_CYCLES = 800;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS = 30;
	localparam int HOLD_OFF_CYCLES = 500;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	// Pacing of each side: full rate, or random idle/stall stretches
	typedef enum logic {
		PACE_FULL,
		PACE_RANDOM
	} pace_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// Set being collected by the predictor, and the sorted results it owes
	logic signed [DATA_W-1:0] set_values[$];
	logic set_overflow = 1'b0;
	result_t pending_results[$];

	pace_t send_pace = PACE_FULL;
	pace_t recv_pace = PACE_FULL;
	int hold_request = 0;
	int hold_left = 0;
	int stall_run = 0;
	logic stall_now = 1'b0;

	int items_sent = 0;
	int sets_closed = 0;
	int truncated_sets = 0;
	int results_checked = 0;
	int bad_results = 0;
	int quiet_cycles = 0;
	result_t want;

	merge_sorter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor: store values up to capacity, flag anything beyond it, and on
	// the value flagged last sort the stored ones and queue one result each.
	// ------------------------------------------------------------------------
	task automatic predict_sorted_set(input logic signed [DATA_W-1:0] v, input logic is_last);
		logic signed [DATA_W-1:0] ordered[$];
		logic signed [DATA_W-1:0] pick;
		result_t r;
		int j;
		if (set_values.size() < MAX_ITEMS) begin
			set_values.push_back(v);
		end else begin
			set_overflow = 1'b1;
		end
		if (!is_last)
			return;
		// Insertion sort, ascending signed; equal values are indistinguishable
		ordered = set_values;
		for (int i = 1; i < ordered.size(); i++) begin
			pick = ordered[i];
			j = i - 1;
			while (j >= 0 && ordered[j] > pick) begin
				ordered[j + 1] = ordered[j];
				j--;
			end
			ordered[j + 1] = pick;
		end
		for (int k = 0; k < ordered.size(); k++) begin
			r.sorted_value = ordered[k];
			r.end_of_set = (k == ordered.size() - 1);
			r.truncated = set_overflow;
			pending_results.push_back(r);
		end
		sets_closed++;
		if (set_overflow)
			truncated_sets++;
		// Start a fresh set
		set_values.delete();
		set_overflow = 1'b0;
	endtask

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int roll;
		if (send_pace == PACE_FULL)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Bias toward extremes and near-zero duplicates, otherwise full-range noise
	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// Mostly small sets, some medium ones
	function automatic int pick_set_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 8);
		return $urandom_range(9, 20);
	endfunction

	// ------------------------------------------------------------------------
	// Send one value: present it at the falling edge, hold it until the
	// transfer happens at a rising edge, record it, then idle for a gap.
	// Valid stays high straight into the next value when there is no gap.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic signed [DATA_W-1:0] v, input logic is_last);
		int gap;
		@(negedge clk);
		item_valid <= 1'b1;
		item.value <= v;
		item.last <= is_last;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		predict_sorted_set(v, is_last);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_random_set(input int size);
		for (int k = 0; k < size; k++)
			send_item(rand_value(), k == size - 1);
	endtask

	// Drop valid and wait until every predicted result has been seen
	task automatic wait_drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// One-value sets at the extremes of the range, at zero and at minus one
	task automatic test_single_values();
		send_pace = PACE_FULL;
		recv_pace = PACE_FULL;
		send_item(VAL_MIN, 1'b1);
		send_item(VAL_MAX, 1'b1);
		send_item('0, 1'b1);
		send_item(-1, 1'b1);
		wait_drain();
	endtask

	// Mixed signs, alternating bit patterns, duplicates, sorted and reversed input
	task automatic test_small_sets();
		send_pace = PACE_RANDOM;
		recv_pace = PACE_RANDOM;
		send_item(VAL_MAX, 1'b0);
		send_item(VAL_MIN, 1'b0);
		send_item('0, 1'b0);
		send_item(-1, 1'b0);
		send_item(1, 1'b0);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b0);
		send_item(VAL_MIN, 1'b1);
		send_item(7, 1'b0);
		send_item(-7, 1'b0);
		send_item(7, 1'b0);
		send_item(7, 1'b1);
		send_item(-30, 1'b0);
		send_item(10, 1'b0);
		send_item(20, 1'b1);
		send_item(30, 1'b0);
		send_item(20, 1'b0);
		send_item(-10, 1'b1);
		wait_drain();
	endtask

	// Full store, then one value dropped mid-set and the closing value dropped
	task automatic test_capacity();
		send_pace = PACE_RANDOM;
		recv_pace = PACE_RANDOM;
		send_random_set(MAX_ITEMS + 2);
		wait_drain();
	endtask

	// Random sets back to back, changing the pacing of both sides as it goes
	task automatic test_random_sets(input int budget);
		int start;
		int size;
		start = items_sent;
		while (items_sent - start < budget) begin
			case ($urandom_range(0, 3))
				0: begin send_pace = PACE_FULL; recv_pace = PACE_FULL; end
				1: begin send_pace = PACE_FULL; recv_pace = PACE_RANDOM; end
				2: begin send_pace = PACE_RANDOM; recv_pace = PACE_FULL; end
				default: begin send_pace = PACE_RANDOM; recv_pace = PACE_RANDOM; end
			endcase
			size = pick_set_size();
			send_random_set(size);
		end
		wait_drain();
	endtask

	// Hold the output off for a long stretch while sets keep arriving, so the
	// block backs up and the input side stalls
	task automatic test_output_hold_off();
		send_pace = PACE_FULL;
		recv_pace = PACE_RANDOM;
		hold_request = HOLD_OFF_CYCLES;
		for (int s = 0; s < 3; s++)
			send_random_set($urandom_range(4, 8));
		wait_drain();
	endtask

	// Pause the sender after each set until its last result is out
	task automatic test_set_by_set();
		send_pace = PACE_RANDOM;
		recv_pace = PACE_RANDOM;
		for (int s = 0; s < 3; s++) begin
			send_random_set($urandom_range(1, 6));
			wait_drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Output stall: a forced hold-off takes priority and is counted down here;
	// otherwise no stall at full pace, else alternate random runs of stall and pass.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (recv_pace == PACE_FULL) begin
			result_stall <= 1'b0;
			stall_run = 0;
		end else begin
			if (stall_run == 0) begin
				stall_now = ($urandom_range(0, 2) == 0);
				if (stall_now)
					stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 3);
				else
					stall_run = $urandom_range(1, 8);
			end
			stall_run--;
			result_stall <= stall_now;
		end
	end

	// ------------------------------------------------------------------------
	// Result check: every output transfer must match the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				bad_results++;
				if (bad_results <= MAX_REPORTS)
					$display("%0t: unexpected result value=%0d end_of_set=%0b truncated=%0b",
						$realtime, result.sorted_value, result.end_of_set, result.truncated);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (result.sorted_value !== want.sorted_value
						|| result.end_of_set !== want.end_of_set
						|| result.truncated !== want.truncated) begin
					bad_results++;
					if (bad_results <= MAX_REPORTS)
						$display("%0t: mismatch expected value=%0d end=%0b trunc=%0b, got value=%0d end=%0b trunc=%0b",
							$realtime, want.sorted_value, want.end_of_set, want.truncated,
							result.sorted_value, result.end_of_set, result.truncated);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: count cycles with no transfer on either side
	// ------------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles, %0d results still owed",
			WATCHDOG_LIMIT, pending_results.size());
		$display("tb NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_values();
		test_small_sets();
		test_capacity();
		test_output_hold_off();
		test_random_sets(RANDOM_ITEMS);
		test_set_by_set();

		// Give the block time to emit anything it should not
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		bad_results += pending_results.size();

		$display("covered %0d values in %0d sets (%0d of them truncated)",
			items_sent, sets_closed, truncated_sets);
		$display("checked %0d sorted results, %0d failures", results_checked, bad_results);
		if (bad_results == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
